// ===== rtl/assert_macros.svh =====
// Assertion helper macros for the interval paint tree RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ipst_pkg.sv =====
// Shared types and constants for the interval paint segment tree.
// No dependencies; imported by ipst_stack, the core and the testbench.
package ipst_pkg;

    localparam int FIELD_POS_BITS   = 18;
    localparam int FIELD_LABEL_BITS = 16;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_PAINT = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_VISIT,
        S_PD_TOP,
        S_PD_LEFT,
        S_PD_RIGHT,
        S_LEAF,
        S_OUT,
        S_POP
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctrl;

endpackage

// ===== rtl/ipst_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ipst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ipst_stack.sv =====
// Descent stack holding the pending right children of a paint traversal.
// Depends on ipst_pkg for the push/pop control struct.
module ipst_stack #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ipst_pkg::t_stk_ctrl i_ctrl,
    input  logic [DW-1:0]      i_data,
    output logic [DW-1:0]      o_top,
    output logic               o_empty
);
    import ipst_pkg::*;

    localparam int PTR_BITS = $clog2(DEPTH);

    logic [DW-1:0]       r_ent [DEPTH];
    logic [PTR_BITS-1:0] r_sp;
    logic [PTR_BITS-1:0] top_idx;

    assign top_idx = r_sp - PTR_BITS'(1);
    assign o_top   = r_ent[top_idx];
    assign o_empty = (r_sp == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_ctrl.push) begin
            r_sp <= r_sp + PTR_BITS'(1);
        end else if (i_ctrl.pop) begin
            r_sp <= top_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_ent[r_sp] <= i_data;
        end
    end

endmodule

// ===== rtl/interval_paint_segment_tree_core.sv =====
// Top level of the interval paint segment tree: traversal sequencer and datapath.
// Depends on ipst_pkg, ipst_ram, ipst_stack and assert_macros.svh.
//
//   channel | direction | handshake                  | payload
//   input   | in        | i_in_valid / o_in_stall    | command, range, label, position
//   output  | out       | o_out_valid / i_out_stall  | found_label
//
// After reset a clearing pass writes zero to every node, during which no request is
// taken. In a query each tree level costs one read of the node and two of its children
// on the single read port; the work of a paint is set by the two boundary paths and
// their off-path siblings. The input channel stalls while a request is in work; a
// stalled result only holds up the next query's end.
`include "assert_macros.svh"

module interval_paint_segment_tree_core #(
    parameter int POSITION_BITS = 18,
    parameter int LABEL_BITS    = 16,
    parameter int NODE_COUNT    = 524288
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_command,
    input  logic [ipst_pkg::FIELD_POS_BITS-1:0]  i_range_low,
    input  logic [ipst_pkg::FIELD_POS_BITS-1:0]  i_range_high,
    input  logic [ipst_pkg::FIELD_LABEL_BITS-1:0] i_paint_label,
    input  logic [ipst_pkg::FIELD_POS_BITS-1:0]  i_query_position,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [ipst_pkg::FIELD_LABEL_BITS-1:0] o_found_label
);
    import ipst_pkg::*;

    localparam int K_BITS    = POSITION_BITS + 1;
    localparam int LVL_BITS  = $clog2(POSITION_BITS + 1);
    localparam int ADDR_BITS = $clog2(NODE_COUNT);
    localparam int ENT_BITS  = K_BITS + POSITION_BITS + LVL_BITS;
    localparam logic [31:0] LAST_POS = 32'((64'd1 << POSITION_BITS) - 64'd1);

    t_state r_state, n_state;

    // Request held for the whole traversal.
    logic                     r_cmd;
    logic [FIELD_POS_BITS-1:0] r_lo, r_hi;
    logic [LABEL_BITS-1:0]    r_label;
    logic [POSITION_BITS-1:0] r_pos;

    // Current node: index, first position of its segment, tree level.
    logic [K_BITS-1:0]        r_k;
    logic [POSITION_BITS-1:0] r_seg_lo;
    logic [LVL_BITS-1:0]      r_lvl;
    logic [LABEL_BITS-1:0]    r_top;
    logic [LABEL_BITS-1:0]    r_result;
    logic [ADDR_BITS-1:0]     r_clr_addr;
    logic                     r_rd_oor;
    logic                     r_out_valid;
    logic [FIELD_LABEL_BITS-1:0] r_found;

    logic [POSITION_BITS-1:0] span, half, right_bit, mid, seg_hi, right_lo;
    logic [K_BITS-1:0]        child_l, child_r;
    logic [LVL_BITS-1:0]      lvl_next;
    logic                     is_query, at_leaf, disjoint, covered, go_right;
    logic                     accept, out_load, clr_last;

    logic [K_BITS-1:0]        rd_k, wr_k;
    logic                     tree_we, ram_we;
    logic [LABEL_BITS-1:0]    tree_wdata, ram_wdata, ram_rdata, rd_value;
    logic [ADDR_BITS-1:0]     ram_waddr;

    t_stk_ctrl                stk_ctrl;
    logic [ENT_BITS-1:0]      stk_top;
    logic                     stk_empty;

    // Segment geometry follows from the aligned first position and the level.
    assign span      = {POSITION_BITS{1'b1}} >> r_lvl;
    assign half      = span >> 1;
    assign right_bit = span & ~half;
    assign seg_hi    = r_seg_lo | span;
    assign mid       = r_seg_lo | half;
    assign right_lo  = r_seg_lo | right_bit;
    assign child_l   = {r_k[K_BITS-2:0], 1'b0};
    assign child_r   = {r_k[K_BITS-2:0], 1'b1};
    assign lvl_next  = r_lvl + LVL_BITS'(1);

    assign is_query = (r_cmd == CMD_QUERY);
    assign at_leaf  = (r_lvl == LVL_BITS'(POSITION_BITS));
    assign disjoint = (32'(r_hi) < 32'(r_seg_lo)) || (32'(seg_hi) < 32'(r_lo));
    assign covered  = (32'(r_lo) <= 32'(r_seg_lo)) && (32'(seg_hi) <= 32'(r_hi));
    assign go_right = (r_pos > mid);

    assign accept   = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign clr_last = (r_clr_addr == ADDR_BITS'(NODE_COUNT - 1));

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_found_label = r_found;

    // Nodes beyond the store read as zero and swallow writes.
    assign rd_value = r_rd_oor ? '0 : ram_rdata;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (clr_last) n_state = S_IDLE;
            S_IDLE:     if (i_in_valid) n_state = S_VISIT;
            S_VISIT: begin
                if (is_query) begin
                    n_state = at_leaf ? S_LEAF : S_PD_TOP;
                end else if (disjoint || covered) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_PD_TOP;
                end
            end
            S_PD_TOP:   n_state = S_PD_LEFT;
            S_PD_LEFT:  n_state = S_PD_RIGHT;
            S_PD_RIGHT: n_state = S_VISIT;
            S_LEAF:     n_state = S_OUT;
            S_OUT:      if (out_load) n_state = S_IDLE;
            S_POP:      n_state = stk_empty ? S_IDLE : S_VISIT;
            default:    n_state = S_IDLE;
        endcase
    end

    // Memory access and stack control for each state.
    always_comb begin
        rd_k       = r_k;
        wr_k       = r_k;
        tree_we    = 1'b0;
        tree_wdata = r_label;
        stk_ctrl   = '0;
        unique case (r_state)
            S_VISIT: begin
                // Covered nodes take the paint label outright.
                if (!is_query && !disjoint && covered) begin
                    tree_we = 1'b1;
                end
            end
            S_PD_TOP:   rd_k = child_l;
            S_PD_LEFT: begin
                rd_k       = child_r;
                wr_k       = child_l;
                tree_wdata = r_top;
                tree_we    = (rd_value < r_top);
            end
            S_PD_RIGHT: begin
                wr_k       = child_r;
                tree_wdata = r_top;
                tree_we    = (rd_value < r_top);
                stk_ctrl.push = !is_query;
            end
            S_POP:      stk_ctrl.pop = !stk_empty;
            default: ;
        endcase
    end

    assign ram_we    = (r_state == S_CLEAR) ||
                       (tree_we && (32'(wr_k) < 32'(NODE_COUNT)));
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : ADDR_BITS'(wr_k);
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : tree_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_BITS'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_rd_oor <= !(32'(rd_k) < 32'(NODE_COUNT));
        if (out_load) begin
            r_found <= FIELD_LABEL_BITS'(r_result);
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cmd    <= i_command;
                    r_lo     <= i_range_low;
                    r_hi     <= i_range_high;
                    r_label  <= LABEL_BITS'(i_paint_label);
                    // A position above the top walks to the last leaf.
                    r_pos    <= (32'(i_query_position) > LAST_POS) ?
                                {POSITION_BITS{1'b1}} : POSITION_BITS'(i_query_position);
                    r_k      <= K_BITS'(1);
                    r_seg_lo <= '0;
                    r_lvl    <= '0;
                end
            end
            S_PD_TOP:  r_top <= rd_value;
            S_PD_RIGHT: begin
                r_lvl <= lvl_next;
                if (is_query && go_right) begin
                    r_k      <= child_r;
                    r_seg_lo <= right_lo;
                end else begin
                    r_k <= child_l;
                end
            end
            S_LEAF:    r_result <= rd_value;
            S_POP: begin
                if (!stk_empty) begin
                    {r_k, r_seg_lo, r_lvl} <= stk_top;
                end
            end
            default: ;
        endcase
    end

    ipst_ram #(
        .WIDTH (LABEL_BITS),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ADDR_BITS'(rd_k)),
        .o_rdata (ram_rdata)
    );

    ipst_stack #(
        .DW    (ENT_BITS),
        .DEPTH (POSITION_BITS + 1)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (stk_ctrl),
        .i_data  ({child_r, right_lo, lvl_next}),
        .o_top   (stk_top),
        .o_empty (stk_empty)
    );

    // A result appears only after the leaf has been read for a query.
    `ASSERT_IMP(a_out_from_query, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == S_OUT && !$past(r_cmd), "result without a query")
    // The idle state never writes the node store.
    `ASSERT_IMP(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !ram_we,
        "node write while idle")
    // Every accepted request starts at the root.
    `ASSERT_NXT(a_start_root, i_clk, i_rst_n, accept,
        r_state == S_VISIT && r_k == K_BITS'(1) && r_lvl == '0, "request not at root")
    // The descent never passes the leaf level.
    `ASSERT_IMP(a_level_bound, i_clk, i_rst_n, r_state == S_VISIT,
        32'(r_lvl) <= 32'(POSITION_BITS), "descent below leaves")

endmodule

// ===== tb/sv/tb_interval_paint_segment_tree_core.sv =====
// Testbench for interval_paint_segment_tree_core: directed and random paint/query requests
// checked against a behavioral segment tree kept in the bench or hand-typed labels.
// Depends on ipst_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_interval_paint_segment_tree_core;
    import ipst_pkg::*;

    localparam int POS_BITS   = FIELD_POS_BITS;
    localparam int LBL_BITS   = FIELD_LABEL_BITS;
    localparam int TREE_NODES = 524288;
    localparam int unsigned LAST_POS = (1 << POS_BITS) - 1;
    // The clearing pass after reset alone idles both channels.
    localparam int WATCHDOG_LIMIT = 4 * TREE_NODES;
    localparam int ITEMS_PER_PHASE = 380;

    // Idle modes, one per random phase.
    localparam int MODE_NONE   = 0;
    localparam int MODE_SENDER = 1;
    localparam int MODE_STALL  = 2;
    localparam int MODE_BOTH   = 3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_command;
    logic [POS_BITS-1:0] i_range_low;
    logic [POS_BITS-1:0] i_range_high;
    logic [LBL_BITS-1:0] i_paint_label;
    logic [POS_BITS-1:0] i_query_position;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [LBL_BITS-1:0] o_found_label;

    interval_paint_segment_tree_core dut (.*);

    // Bench copy of the tree; node 1 is the root, node k has children 2k and 2k+1.
    bit [LBL_BITS-1:0]   tree_label [TREE_NODES];
    logic [LBL_BITS-1:0] expected_labels [$];
    int                  mismatch_count;
    int                  idle_mode;
    int                  quiet_cycles;

    typedef struct {
        logic                cmd;
        logic [POS_BITS-1:0] lo;
        logic [POS_BITS-1:0] hi;
        logic [LBL_BITS-1:0] lbl;
        logic [POS_BITS-1:0] pos;
        bit                  typed;     // found label below is typed in by hand
        logic [LBL_BITS-1:0] found;
    } t_request_row;

    always #5 i_clk = ~i_clk;

    function automatic bit [LBL_BITS-1:0] node_read(int unsigned k);
        return (k < TREE_NODES) ? tree_label[k] : '0;
    endfunction

    // Each child keeps the larger of its own label and its parent's.
    function automatic void push_labels(int unsigned k);
        bit [LBL_BITS-1:0] top;
        top = node_read(k);
        if (2 * k < TREE_NODES && tree_label[2 * k] < top) tree_label[2 * k] = top;
        if (2 * k + 1 < TREE_NODES && tree_label[2 * k + 1] < top) tree_label[2 * k + 1] = top;
    endfunction

    function automatic void paint_range(int unsigned lo, int unsigned hi, int unsigned seg_lo,
                                        int unsigned seg_hi, int unsigned k,
                                        bit [LBL_BITS-1:0] lbl);
        int unsigned mid;
        if (hi < seg_lo || seg_hi < lo) return;
        if (lo <= seg_lo && seg_hi <= hi) begin
            if (k < TREE_NODES) tree_label[k] = lbl;
            return;
        end
        mid = seg_lo + (seg_hi - seg_lo) / 2;
        push_labels(k);
        paint_range(lo, hi, seg_lo, mid, 2 * k, lbl);
        paint_range(lo, hi, mid + 1, seg_hi, 2 * k + 1, lbl);
    endfunction

    function automatic bit [LBL_BITS-1:0] label_at(int unsigned pos);
        int unsigned seg_lo;
        int unsigned seg_hi;
        int unsigned k;
        int unsigned mid;
        seg_lo = 0;
        seg_hi = LAST_POS;
        k = 1;
        while (seg_lo != seg_hi) begin
            mid = seg_lo + (seg_hi - seg_lo) / 2;
            push_labels(k);
            if (pos <= mid) begin
                seg_hi = mid;
                k = 2 * k;
            end else begin
                seg_lo = mid + 1;
                k = 2 * k + 1;
            end
        end
        return node_read(k);
    endfunction

    task automatic report_mismatch(string what, logic [LBL_BITS-1:0] got,
                                   logic [LBL_BITS-1:0] want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Presents one request from the falling edge on and returns once it has been
    // accepted; the new request is folded into the tree and, for a query, its
    // found label is queued.
    task automatic issue_request(t_request_row r);
        bit [LBL_BITS-1:0] found;
        int unsigned       idle_pct;
        idle_pct = (idle_mode == MODE_BOTH) ? 6 : 83;
        if (idle_mode == MODE_SENDER || idle_mode == MODE_BOTH) begin
            while ($urandom_range(99) < idle_pct) begin
                i_in_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid       = 1'b1;
        i_command        = r.cmd;
        i_range_low      = r.lo;
        i_range_high     = r.hi;
        i_paint_label    = r.lbl;
        i_query_position = r.pos;
        do @(posedge i_clk); while (o_in_stall);
        if (r.cmd == CMD_PAINT) begin
            paint_range(r.lo, r.hi, 0, LAST_POS, 1, r.lbl);
        end else begin
            found = label_at(r.pos);
            expected_labels.push_back(r.typed ? r.found : found);
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain_results();
        while (expected_labels.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver stall, redrawn every cycle according to the idle mode of the phase.
    always @(negedge i_clk) begin
        if (idle_mode == MODE_STALL)
            i_out_stall <= ($urandom_range(99) < 83);
        else if (idle_mode == MODE_BOTH)
            i_out_stall <= ($urandom_range(99) < 6);
        else
            i_out_stall <= 1'b0;
    end

    // Result checker: every accepted result must match the oldest queued label.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_labels.size() == 0)
                report_mismatch("unexpected result found_label", o_found_label, '0);
            else if (o_found_label !== expected_labels[0]) begin
                report_mismatch("found_label", o_found_label, expected_labels[0]);
                void'(expected_labels.pop_front());
            end else
                void'(expected_labels.pop_front());
        end
    end

    // Watchdog: counts cycles in which neither channel moves a request or result.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    t_request_row directed_rows [$];
    int unsigned  paint_lbl;
    int unsigned  last_lo;
    int unsigned  last_hi;

    // Builds one random request. Most paints carry increasing labels over short
    // ranges, and most queries land near the edges of the latest paint.
    function automatic t_request_row random_request();
        t_request_row r;
        int unsigned  span;
        int unsigned  pick;
        r.typed = 1'b0;
        r.found = '0;
        r.cmd   = ($urandom_range(99) < 40) ? CMD_PAINT : CMD_QUERY;
        r.lo    = $urandom;
        r.hi    = $urandom;
        r.lbl   = $urandom;
        r.pos   = $urandom;
        if (r.cmd == CMD_PAINT) begin
            pick = $urandom_range(99);
            span = (pick < 55) ? $urandom_range(255) : $urandom_range(65535);
            if (pick < 75) begin
                r.hi = (r.lo + span > LAST_POS) ? LAST_POS : r.lo + span;
            end else if (pick < 85) begin
                r.lo = (pick < 80) ? 0 : LAST_POS - span;
                r.hi = (pick < 80) ? span : LAST_POS;
            end else if (pick < 92 && r.lo <= r.hi) begin
                // Empty range: low end above the high end.
                r.hi = r.lo;
                r.lo = r.hi + 1 + $urandom_range(40);
            end
            if ($urandom_range(99) < 90) begin
                paint_lbl = (paint_lbl + 1 + $urandom_range(30)) & 16'hFFFF;
                r.lbl = paint_lbl;
            end
            last_lo = r.lo;
            last_hi = r.hi;
        end else begin
            pick = $urandom_range(99);
            if (pick < 30)
                r.pos = (last_lo + $urandom_range(4) - 2) & LAST_POS;
            else if (pick < 60)
                r.pos = (last_hi + $urandom_range(4) - 2) & LAST_POS;
            else if (pick < 65)
                r.pos = pick[0] ? LAST_POS : 0;
        end
        return r;
    endfunction

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_command        = CMD_QUERY;
        i_range_low      = '0;
        i_range_high     = '0;
        i_paint_label    = '0;
        i_query_position = '0;
        i_out_stall      = 1'b0;
        idle_mode        = MODE_NONE;
        mismatch_count   = 0;
        quiet_cycles     = 0;
        paint_lbl        = 100;
        last_lo          = 0;
        last_hi          = LAST_POS;

        // Directed rows: cmd, lo, hi, label, position, typed, found.
        directed_rows = '{
            '{CMD_QUERY, 0, 0, 0, 0, 1, 0},                        // untouched after reset
            '{CMD_QUERY, 18'h3FFFF, 18'h3FFFF, 16'hFFFF, LAST_POS, 1, 0},
            '{CMD_PAINT, 0, LAST_POS, 5, 18'h2AAAA, 0, 0},         // whole range, root only
            '{CMD_QUERY, 0, 0, 0, 0, 1, 5},
            '{CMD_QUERY, 0, 0, 0, LAST_POS, 1, 5},
            '{CMD_PAINT, 500, 100, 9, 0, 0, 0},                    // empty range paints no label
            '{CMD_QUERY, 0, 0, 0, 300, 1, 5},
            '{CMD_PAINT, LAST_POS, LAST_POS, 16'hFFFF, 0, 0, 0},   // single top leaf
            '{CMD_QUERY, 0, 0, 0, LAST_POS, 1, 16'hFFFF},
            '{CMD_QUERY, 0, 0, 0, LAST_POS - 1, 1, 5},
            '{CMD_PAINT, 0, 0, 7, LAST_POS, 0, 0},                 // single bottom leaf
            '{CMD_QUERY, 18'h3FFFF, 18'h15555, 16'hA5A5, 0, 1, 7}, // query ignores paint fields
            '{CMD_QUERY, 0, 0, 0, 1, 1, 5},
            '{CMD_PAINT, 10, 20, 3, 0, 0, 0},                      // lower label under a push
            '{CMD_QUERY, 0, 0, 0, 15, 0, 0},
            '{CMD_PAINT, 1000, 70000, 40, 0, 0, 0},
            '{CMD_QUERY, 0, 0, 0, 999, 0, 0},
            '{CMD_QUERY, 0, 0, 0, 1000, 0, 0},
            '{CMD_QUERY, 0, 0, 0, 70000, 0, 0},
            '{CMD_QUERY, 0, 0, 0, 70001, 0, 0},
            '{CMD_PAINT, 18'h20000, LAST_POS, 41, 0, 0, 0},        // upper half exactly
            '{CMD_QUERY, 0, 0, 0, 18'h1FFFF, 0, 0},
            '{CMD_QUERY, 0, 0, 0, 18'h20000, 0, 0},
            '{CMD_PAINT, LAST_POS, 0, 16'hFFFF, 0, 0, 0},          // widest empty range
            '{CMD_QUERY, 0, 0, 0, 18'h20000, 0, 0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The block takes nothing during its clearing pass; the first request waits.
        foreach (directed_rows[n]) issue_request(directed_rows[n]);
        drain_results();

        // Random phases, each under its own idle mode; the sender pauses between
        // phases until every queued result has come back.
        for (int ph = 0; ph < 4; ph++) begin
            idle_mode = (ph == 0) ? MODE_NONE : (ph == 1) ? MODE_SENDER :
                        (ph == 2) ? MODE_STALL : MODE_BOTH;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) issue_request(random_request());
            drain_results();
        end
        idle_mode = MODE_NONE;
        repeat (300) @(posedge i_clk);

        if (mismatch_count == 0 && expected_labels.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
